[sv/rld_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package rld_pkg;

    localparam longint DEG90       = 64'sd2304000;
    localparam longint DEG180      = 64'sd4608000;
    localparam longint DEG360      = 64'sd9216000;
    localparam longint CORDIC_GAIN = 64'sd10188014;

    localparam int VW = 17;
    localparam int SW = 21;
    localparam int CW = 6;
    localparam int DW = 22;
    localparam int RW = 7;
    localparam int XW = 34;
    localparam int ZW = 25;
    localparam int QW = 42;

    localparam int CORD_STEPS = 16;
    localparam int DIV_STEPS  = 22;
    localparam int SQRT_STEPS = 21;
    localparam int SQRT_TOP   = 40;

    localparam logic signed [SW-1:0] ONE_Q14   = 21'sd16384;
    localparam logic signed [15:0]   ANG_LIMIT = 16'sd18000;
    localparam logic [14:0]          JUMP_RESET = 15'd3000;

    typedef logic signed [ZW-1:0] t_atan;

    localparam t_atan ATAN_TAB [CORD_STEPS] = '{
        25'sd1152000, 25'sd680065, 25'sd359328, 25'sd182400,
        25'sd91554,   25'sd45822,  25'sd22916,  25'sd11459,
        25'sd5730,    25'sd2865,   25'sd1432,   25'sd716,
        25'sd358,     25'sd179,    25'sd90,     25'sd45
    };

    typedef struct packed {
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
    } t_uvec;

    typedef struct packed {
        logic       start;
        logic       scan_step;
        logic       tail_load;
        logic       div_step;
        logic       avg_add;
        logic       cord_init;
        logic       cord_step;
        logic [3:0] k;
        logic       sq_x;
        logic       sq_y;
        logic       sqrt_init;
        logic       sqrt_step;
        logic       dist_load;
        logic       publish;
    } t_cmd;

    typedef struct packed {
        logic any;
        logic ring;
        logic need_avg;
        logic last;
        logic tail_avg;
        logic out_free;
    } t_sts;

    // elaboration only: unit vector of a sensor at angle z
    function automatic t_uvec f_sensor_vec(input longint z_in);
        longint z;
        longint x;
        longint y;
        longint nx;
        int     k;
        t_uvec  v;
        z = z_in;
        x = CORDIC_GAIN;
        y = 0;
        if (z >= DEG180) z = z - DEG360;
        if (z > DEG90) begin
            x = 0;
            y = CORDIC_GAIN;
            z = z - DEG90;
        end else if (z < -DEG90) begin
            x = 0;
            y = -CORDIC_GAIN;
            z = z + DEG90;
        end
        for (k = 0; k < CORD_STEPS; k++) begin
            if (z >= 0) begin
                nx = x - (y >>> k);
                y  = y + (x >>> k);
                z  = z - longint'(ATAN_TAB[k]);
            end else begin
                nx = x + (y >>> k);
                y  = y - (x >>> k);
                z  = z + longint'(ATAN_TAB[k]);
            end
            x = nx;
        end
        v.x = VW'((x + 512) >>> 10);
        v.y = VW'((y + 512) >>> 10);
        return v;
    endfunction

endpackage

`default_nettype wire

[sv/rld_req_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface rld_req_if;
    logic        valid;
    logic        ready;
    logic [31:0] ring_bits;
    logic        right_side;
    logic        left_side;

    modport source (output valid, output ring_bits, output right_side, output left_side,
                    input ready);
    modport sink (input valid, input ring_bits, input right_side, input left_side,
                  output ready);
endinterface

`default_nettype wire

[sv/rld_res_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface rld_res_if;
    logic               valid;
    logic               ready;
    logic               line_found;
    logic               ring_hit;
    logic               side_hit;
    logic [4:0]         cluster_count;
    logic signed [15:0] line_angle;
    logic [14:0]        line_distance;

    modport source (output valid, output line_found, output ring_hit, output side_hit,
                    output cluster_count, output line_angle, output line_distance,
                    input ready);
    modport sink (input valid, input line_found, input ring_hit, input side_hit,
                  input cluster_count, input line_angle, input line_distance,
                  output ready);
endinterface

`default_nettype wire

[sv/ring_line_direction_estimator_core.sv]
// channel  dir  payload                                                   handshake
// i_req    in   ring_bits, right_side, left_side                          valid/ready
// o_res    out  line_found, ring_hit, side_hit, cluster_count,            valid/ready
//               line_angle, line_distance
// cfg      in   i_cfg_wdata (max_angle_jump)                              i_cfg_we
//
// one request at a time: the ring scan takes one sensor a cycle, paused while the
// serial divider averages each ring cluster; then cordic, root and distance divide
// reset is synchronous; no clearing pass, max_angle_jump returns to 3000
// a request is taken while the last result still waits; the final write waits
// for the output register to free
`timescale 1ns / 1ps
`default_nettype none

module ring_line_direction_estimator_core
    import rld_pkg::*;
#(
    parameter int RING_SENSORS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [14:0] i_cfg_wdata,
    rld_req_if.sink          i_req,
    rld_res_if.source        o_res
);

    t_cmd w_cmd;
    t_sts w_sts;

    rld_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    rld_dp #(
        .RING_SENSORS (RING_SENSORS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_ring_bits     (i_req.ring_bits),
        .i_right_side    (i_req.right_side),
        .i_left_side     (i_req.left_side),
        .o_out_valid     (o_res.valid),
        .i_out_ready     (o_res.ready),
        .o_line_found    (o_res.line_found),
        .o_ring_hit      (o_res.ring_hit),
        .o_side_hit      (o_res.side_hit),
        .o_cluster_count (o_res.cluster_count),
        .o_line_angle    (o_res.line_angle),
        .o_line_distance (o_res.line_distance)
    );

endmodule

`default_nettype wire

[sv/rld_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module rld_ctrl
    import rld_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_PREP, S_SCAN, S_AVG, S_ADD, S_TAIL, S_CINIT, S_CORD,
        S_SQX, S_SQY, S_SINIT, S_SQRT, S_DLOAD, S_DDIV, S_OUT
    } t_state;

    t_state     r_state, n_state;
    logic [4:0] r_cnt, n_cnt;
    logic       r_scan_over, n_scan_over;
    logic       r_from_tail, n_from_tail;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_scan_over = r_scan_over;
        n_from_tail = r_from_tail;
        o_cmd       = '0;
        o_cmd.k     = r_cnt[3:0];
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_scan_over = 1'b0;
                    n_from_tail = 1'b0;
                    n_state     = S_PREP;
                end
            end
            S_PREP: begin
                if (!i_sts.any) n_state = S_OUT;
                else if (i_sts.ring) n_state = S_SCAN;
                else n_state = S_CINIT;
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.last) n_scan_over = 1'b1;
                if (i_sts.need_avg) begin
                    n_cnt   = '0;
                    n_state = S_AVG;
                end else if (i_sts.last) begin
                    n_state = S_TAIL;
                end
            end
            S_AVG: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'(DIV_STEPS - 1)) n_state = S_ADD;
            end
            S_ADD: begin
                o_cmd.avg_add = 1'b1;
                if (r_from_tail) n_state = S_CINIT;
                else if (r_scan_over) n_state = S_TAIL;
                else n_state = S_SCAN;
            end
            S_TAIL: begin
                if (i_sts.tail_avg) begin
                    o_cmd.tail_load = 1'b1;
                    n_from_tail     = 1'b1;
                    n_cnt           = '0;
                    n_state         = S_AVG;
                end else begin
                    n_state = S_CINIT;
                end
            end
            S_CINIT: begin
                o_cmd.cord_init = 1'b1;
                n_cnt   = '0;
                n_state = S_CORD;
            end
            S_CORD: begin
                o_cmd.cord_step = 1'b1;
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'(CORD_STEPS - 1)) n_state = S_SQX;
            end
            S_SQX: begin
                o_cmd.sq_x = 1'b1;
                n_state = S_SQY;
            end
            S_SQY: begin
                o_cmd.sq_y = 1'b1;
                n_state = S_SINIT;
            end
            S_SINIT: begin
                o_cmd.sqrt_init = 1'b1;
                n_cnt   = '0;
                n_state = S_SQRT;
            end
            S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'(SQRT_STEPS - 1)) n_state = S_DLOAD;
            end
            S_DLOAD: begin
                o_cmd.dist_load = 1'b1;
                n_cnt   = '0;
                n_state = S_DDIV;
            end
            S_DDIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'(DIV_STEPS - 1)) n_state = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.publish = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_scan_over <= 1'b0;
            r_from_tail <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_scan_over <= n_scan_over;
            r_from_tail <= n_from_tail;
        end
    end

endmodule

`default_nettype wire

[sv/rld_dp.sv]
`timescale 1ns / 1ps
`default_nettype none

module rld_dp
    import rld_pkg::*;
#(
    parameter int RING_SENSORS = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cmd               i_cmd,
    output t_sts                    o_sts,
    input  wire logic               i_cfg_we,
    input  wire logic [14:0]        i_cfg_wdata,
    input  wire logic [31:0]        i_ring_bits,
    input  wire logic               i_right_side,
    input  wire logic               i_left_side,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic                    o_line_found,
    output logic                    o_ring_hit,
    output logic                    o_side_hit,
    output logic [4:0]              o_cluster_count,
    output logic signed [15:0]      o_line_angle,
    output logic [14:0]             o_line_distance
);

    localparam int N  = RING_SENSORS;
    localparam int IW = $clog2(N);

    logic signed [VW-1:0] w_tab_x [N];
    logic signed [VW-1:0] w_tab_y [N];

    for (genvar g = 0; g < N; g++) begin : g_tab
        localparam longint Z  = longint'(g) * DEG360 / RING_SENSORS;
        localparam t_uvec  UV = f_sensor_vec(Z);
        assign w_tab_x[g] = UV.x;
        assign w_tab_y[g] = UV.y;
    end

    function automatic logic [RW+DW-1:0] f_dstep(input logic [RW-1:0] rem,
                                                 input logic [DW-1:0] dq,
                                                 input logic [CW-1:0] d);
        logic [RW-1:0] t;
        logic          ge;
        t  = {rem[RW-2:0], dq[DW-1]};
        ge = (t >= RW'(d));
        if (ge) t = t - RW'(d);
        return {t, dq[DW-2:0], ge};
    endfunction

    logic [N-1:0]         r_bits;
    logic                 r_left, r_right;
    logic [IW-1:0]        r_idx;
    logic signed [SW-1:0] r_ax, r_ay, r_hx, r_hy;
    logic [CW-1:0]        r_ac, r_hc;
    logic                 r_closed;
    logic [4:0]           r_clusters;
    logic signed [SW-1:0] r_vx, r_vy;
    logic [DW-1:0]        r_dqx, r_dqy;
    logic [RW-1:0]        r_remx, r_remy;
    logic [CW-1:0]        r_dd;
    logic                 r_negx, r_negy;
    logic signed [XW-1:0] r_cx, r_cy;
    logic signed [ZW-1:0] r_z;
    logic                 r_zero;
    logic [QW-1:0]        r_sq, r_n, r_res, r_bit;
    logic [14:0]          r_max_jump;
    logic signed [15:0]   r_last;
    logic                 r_was;
    logic                 r_out_valid;
    logic                 r_found, r_ringh, r_sideh;
    logic [4:0]           r_count;
    logic signed [15:0]   r_angle;
    logic [14:0]          r_dist;

    // scan of the ring
    logic                 w_ring, w_full, w_wrap, w_last, w_lit, w_nxt, w_close, w_hold;
    logic [IW-1:0]        w_nidx;
    logic signed [SW-1:0] w_ux, w_uy, w_sx, w_sy, w_tx, w_ty;
    logic [CW-1:0]        w_sc, w_tc;

    assign w_ring  = |r_bits;
    assign w_full  = &r_bits;
    assign w_wrap  = r_bits[N-1] & r_bits[0] & ~w_full;
    assign w_last  = (r_idx == IW'(N - 1));
    assign w_nidx  = w_last ? '0 : r_idx + IW'(1);
    assign w_lit   = r_bits[r_idx];
    assign w_nxt   = r_bits[w_nidx];
    assign w_close = w_lit & ~w_nxt;
    assign w_hold  = ~r_closed & w_wrap;
    assign w_ux    = w_lit ? SW'(w_tab_x[r_idx]) : '0;
    assign w_uy    = w_lit ? SW'(w_tab_y[r_idx]) : '0;
    assign w_sx    = r_ax + w_ux;
    assign w_sy    = r_ay + w_uy;
    assign w_sc    = r_ac + CW'(w_lit);
    assign w_tx    = r_ax + (w_wrap ? r_hx : '0);
    assign w_ty    = r_ay + (w_wrap ? r_hy : '0);
    assign w_tc    = r_ac + (w_wrap ? r_hc : '0);

    // divider load
    logic signed [SW-1:0] w_lx, w_ly, w_mx, w_my;
    logic [CW-1:0]        w_lc;

    assign w_lx = i_cmd.tail_load ? w_tx : w_sx;
    assign w_ly = i_cmd.tail_load ? w_ty : w_sy;
    assign w_lc = i_cmd.tail_load ? w_tc : w_sc;
    assign w_mx = w_lx[SW-1] ? -w_lx : w_lx;
    assign w_my = w_ly[SW-1] ? -w_ly : w_ly;

    logic [RW+DW-1:0] w_stx, w_sty;
    assign w_stx = f_dstep(r_remx, r_dqx, r_dd);
    assign w_sty = f_dstep(r_remy, r_dqy, r_dd);

    logic signed [SW-1:0] w_qx, w_qy;
    assign w_qx = SW'(r_dqx);
    assign w_qy = SW'(r_dqy);

    logic [CW-1:0] w_div;
    assign w_div = (r_clusters == '0) ? CW'(1) : CW'(r_clusters);

    // cordic
    logic signed [XW-1:0] w_x0, w_y0, w_shx, w_shy;
    t_atan                w_at;

    assign w_x0  = {{(XW-SW-10){r_vx[SW-1]}}, r_vx, 10'b0};
    assign w_y0  = {{(XW-SW-10){r_vy[SW-1]}}, r_vy, 10'b0};
    assign w_shx = r_cx >>> i_cmd.k;
    assign w_shy = r_cy >>> i_cmd.k;
    assign w_at  = ATAN_TAB[i_cmd.k];

    // square and root
    logic signed [SW-1:0]     w_mop;
    logic signed [2*SW-1:0]   w_prod;
    logic [QW-1:0]            w_rb;

    assign w_mop  = i_cmd.sq_y ? r_vy : r_vx;
    assign w_prod = w_mop * w_mop;
    assign w_rb   = r_res + r_bit;

    // angle, jump limit and distance
    logic signed [ZW-1:0] w_zabs;
    logic [16:0]          w_zr;
    logic signed [17:0]   w_d;
    logic signed [15:0]   w_ang, w_prev, w_fin;
    logic signed [16:0]   w_diff;
    logic [16:0]          w_adiff, w_wdiff;
    logic [14:0]          w_dist;

    assign w_zabs = r_z[ZW-1] ? -r_z : r_z;
    assign w_zr   = 17'((w_zabs + ZW'(128)) >>> 8);
    assign w_d    = r_z[ZW-1] ? $signed({1'b0, w_zr}) : -$signed({1'b0, w_zr});

    always_comb begin
        if (r_zero) w_ang = '0;
        else if (w_d > 18'(ANG_LIMIT)) w_ang = ANG_LIMIT;
        else if (w_d < -18'(ANG_LIMIT)) w_ang = -ANG_LIMIT;
        else w_ang = 16'(w_d);
    end

    assign w_prev  = r_was ? r_last : w_ang;
    assign w_diff  = 17'(w_ang) - 17'(w_prev);
    assign w_adiff = w_diff[16] ? 17'(-w_diff) : 17'(w_diff);
    assign w_wdiff = (w_adiff > 17'd18000) ? 17'd36000 - w_adiff : w_adiff;
    assign w_fin   = (w_wdiff > {2'b0, r_max_jump}) ? w_prev : w_ang;
    assign w_dist  = (r_dqx > DW'(ONE_Q14)) ? 15'(ONE_Q14) : r_dqx[14:0];

    assign o_sts.any      = w_ring | r_left | r_right;
    assign o_sts.ring     = w_ring;
    assign o_sts.need_avg = w_close & ~w_hold;
    assign o_sts.last     = w_last;
    assign o_sts.tail_avg = w_full | w_wrap;
    assign o_sts.out_free = ~r_out_valid | i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_bits     <= i_ring_bits[N-1:0];
            r_left     <= i_left_side;
            r_right    <= i_right_side;
            r_idx      <= '0;
            r_ax       <= '0;
            r_ay       <= '0;
            r_ac       <= '0;
            r_closed   <= 1'b0;
            r_clusters <= '0;
            r_vx       <= '0;
            if (|i_ring_bits[N-1:0]) r_vy <= '0;
            else r_vy <= i_left_side ? ONE_Q14 : -ONE_Q14;
        end

        if (i_cmd.scan_step) begin
            r_idx <= w_nidx;
            if (w_close) begin
                r_clusters <= r_clusters + 5'd1;
                r_closed   <= 1'b1;
                r_ax       <= '0;
                r_ay       <= '0;
                r_ac       <= '0;
                if (w_hold) begin
                    r_hx <= w_sx;
                    r_hy <= w_sy;
                    r_hc <= w_sc;
                end
            end else begin
                r_ax <= w_sx;
                r_ay <= w_sy;
                r_ac <= w_sc;
            end
        end

        if (i_cmd.tail_load && w_full) r_clusters <= 5'd1;

        if ((i_cmd.scan_step && w_close && !w_hold) || i_cmd.tail_load) begin
            r_negx <= w_lx[SW-1];
            r_negy <= w_ly[SW-1];
            r_dqx  <= DW'($unsigned(w_mx)) + DW'(w_lc >> 1);
            r_dqy  <= DW'($unsigned(w_my)) + DW'(w_lc >> 1);
            r_remx <= '0;
            r_remy <= '0;
            r_dd   <= w_lc;
        end else if (i_cmd.dist_load) begin
            r_dqx  <= DW'(r_res) + DW'(w_div >> 1);
            r_remx <= '0;
            r_dd   <= w_div;
        end else if (i_cmd.div_step) begin
            r_remx <= w_stx[RW+DW-1:DW];
            r_dqx  <= w_stx[DW-1:0];
            r_remy <= w_sty[RW+DW-1:DW];
            r_dqy  <= w_sty[DW-1:0];
        end

        if (i_cmd.avg_add) begin
            r_vx <= r_vx + (r_negx ? -w_qx : w_qx);
            r_vy <= r_vy + (r_negy ? -w_qy : w_qy);
        end

        if (i_cmd.cord_init) begin
            r_zero <= (r_vx == '0) && (r_vy == '0);
            if (w_x0 < 0) begin
                if (w_y0 >= 0) begin
                    r_cx <= w_y0;
                    r_cy <= -w_x0;
                    r_z  <= ZW'(DEG90);
                end else begin
                    r_cx <= -w_y0;
                    r_cy <= w_x0;
                    r_z  <= -ZW'(DEG90);
                end
            end else begin
                r_cx <= w_x0;
                r_cy <= w_y0;
                r_z  <= '0;
            end
        end else if (i_cmd.cord_step) begin
            if (r_cy < 0) begin
                r_cx <= r_cx - w_shy;
                r_cy <= r_cy + w_shx;
                r_z  <= r_z - w_at;
            end else begin
                r_cx <= r_cx + w_shy;
                r_cy <= r_cy - w_shx;
                r_z  <= r_z + w_at;
            end
        end

        if (i_cmd.sq_x) r_sq <= QW'($unsigned(w_prod));
        else if (i_cmd.sq_y) r_sq <= r_sq + QW'($unsigned(w_prod));

        if (i_cmd.sqrt_init) begin
            r_n   <= r_sq;
            r_res <= '0;
            r_bit <= QW'(1) << SQRT_TOP;
        end else if (i_cmd.sqrt_step) begin
            if (r_n >= w_rb) begin
                r_n   <= r_n - w_rb;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end

        if (i_cmd.publish) begin
            if (o_sts.any) begin
                r_found <= 1'b1;
                r_ringh <= w_ring;
                r_sideh <= r_left | r_right;
                r_count <= r_clusters;
                r_angle <= w_fin;
                r_dist  <= w_dist;
            end else begin
                r_found <= 1'b0;
                r_ringh <= 1'b0;
                r_sideh <= 1'b0;
                r_count <= '0;
                r_angle <= r_last;
                r_dist  <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_jump  <= JUMP_RESET;
            r_last      <= '0;
            r_was       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_max_jump <= i_cfg_wdata;
            if (i_cmd.publish) begin
                r_out_valid <= 1'b1;
                r_was       <= o_sts.any;
                if (o_sts.any) r_last <= w_fin;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_line_found    = r_found;
    assign o_ring_hit      = r_ringh;
    assign o_side_hit      = r_sideh;
    assign o_cluster_count = r_count;
    assign o_line_angle    = r_angle;
    assign o_line_distance = r_dist;

endmodule

`default_nettype wire

[sv/rld_chk.sv]
`timescale 1ns / 1ps
`default_nettype none

module rld_chk (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_out_valid,
    input wire logic               i_out_ready,
    input wire logic               i_line_found,
    input wire logic               i_ring_hit,
    input wire logic               i_side_hit,
    input wire logic [4:0]         i_cluster_count,
    input wire logic signed [15:0] i_line_angle,
    input wire logic [14:0]        i_line_distance
);

    a_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_line_found == (i_ring_hit | i_side_hit)))
        else $error("line_found disagrees with hit flags");

    a_clusters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_ring_hit == (i_cluster_count != 5'd0)))
        else $error("cluster count disagrees with ring hit");

    a_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_line_distance <= 15'd16384)
                        && (i_line_found || i_line_distance == 15'd0))
        else $error("distance out of range");

    a_angle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_line_angle >= -16'sd18000) && (i_line_angle <= 16'sd18000))
        else $error("angle out of range");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_line_angle))
        else $error("result dropped while stalled");

endmodule

bind ring_line_direction_estimator_core rld_chk u_rld_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_res.valid),
    .i_out_ready     (o_res.ready),
    .i_line_found    (o_res.line_found),
    .i_ring_hit      (o_res.ring_hit),
    .i_side_hit      (o_res.side_hit),
    .i_cluster_count (o_res.cluster_count),
    .i_line_angle    (o_res.line_angle),
    .i_line_distance (o_res.line_distance)
);

`default_nettype wire

[tb/tb_ring_line_direction_estimator_core.sv]
`timescale 1ns / 1ps

module tb_ring_line_direction_estimator_core;
    import rld_pkg::*;

    localparam int NS = 32;
    localparam longint CYCLE_LIMIT = 10000000;

    typedef struct packed {
        logic [31:0] ring;
        logic        right;
        logic        left;
    } t_sample;

    typedef struct packed {
        logic               found;
        logic               ring;
        logic               side;
        logic [4:0]         clusters;
        logic signed [15:0] angle;
        logic [14:0]        distance;
    } t_estimate;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [14:0] i_cfg_wdata = '0;

    rld_req_if req_ch ();
    rld_res_if res_ch ();

    ring_line_direction_estimator_core #(.RING_SENSORS(NS)) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_req(req_ch.sink),
        .o_res(res_ch.source)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // predictor state
    logic [14:0]        jump_limit;
    logic signed [15:0] held_angle;
    logic               tracking;
    longint             unit_x [NS];
    longint             unit_y [NS];

    t_sample   pending_samples[$];
    t_estimate expected_estimates[$];
    int        errors = 0;
    longint    cycles = 0;
    bit        stim_done = 0;
    int        hold_off = 0;
    bit        pause_send = 0;

    function automatic longint shr(longint v, int k);
        if (v >= 0) return v >>> k;
        return -(((-v) - 1) >>> k) - 1;
    endfunction

    function automatic longint round_div(longint a, longint b);
        if (a >= 0) return (a + b / 2) / b;
        return -(((-a) + b / 2) / b);
    endfunction

    function automatic longint int_sqrt(longint n);
        longint r, b;
        r = 0;
        b = 64'sd1 <<< 62;
        while (b > n) b = b >>> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >>> 1) + b;
            end else begin
                r = r >>> 1;
            end
            b = b >>> 2;
        end
        return r;
    endfunction

    task automatic build_units();
        longint z, x, y, nx;
        for (int i = 0; i < NS; i++) begin
            z = longint'(i) * DEG360 / NS;
            x = CORDIC_GAIN;
            y = 0;
            if (z >= DEG180) z = z - DEG360;
            if (z > DEG90) begin
                x = 0; y = CORDIC_GAIN; z = z - DEG90;
            end else if (z < -DEG90) begin
                x = 0; y = -CORDIC_GAIN; z = z + DEG90;
            end
            for (int k = 0; k < 16; k++) begin
                if (z >= 0) begin
                    nx = x - shr(y, k); y = y + shr(x, k); z = z - longint'(ATAN_TAB[k]);
                end else begin
                    nx = x + shr(y, k); y = y - shr(x, k); z = z + longint'(ATAN_TAB[k]);
                end
                x = nx;
            end
            unit_x[i] = shr(x + 512, 10);
            unit_y[i] = shr(y + 512, 10);
        end
    endtask

    function automatic longint heading(longint vx, longint vy);
        longint x, y, z, nx, d;
        if (vx == 0 && vy == 0) return 0;
        x = vx * 1024; y = vy * 1024; z = 0;
        if (x < 0) begin
            if (y >= 0) begin
                nx = y; y = -x; x = nx; z = DEG90;
            end else begin
                nx = -y; y = x; x = nx; z = -DEG90;
            end
        end
        for (int k = 0; k < 16; k++) begin
            if (y < 0) begin
                nx = x - shr(y, k); y = y + shr(x, k); z = z - longint'(ATAN_TAB[k]);
            end else begin
                nx = x + shr(y, k); y = y - shr(x, k); z = z + longint'(ATAN_TAB[k]);
            end
            x = nx;
        end
        d = -round_div(z, 256);
        if (d > 18000) d = 18000;
        if (d < -18000) d = -18000;
        return d;
    endfunction

    function automatic t_estimate estimate_line(t_sample s);
        t_estimate e;
        longint sx [NS];
        longint sy [NS];
        longint cnt [NS];
        longint vx, vy, dv, len_q, diff, ang, prev;
        int idx, nclus;
        bit lit, nxt, ring, side;
        vx = 0; vy = 0; idx = 0; nclus = 0;
        ring = s.ring != 0;
        side = s.right | s.left;
        e = '0;
        if (!ring && !side) begin
            tracking = 1'b0;
            e.angle = held_angle;
            return e;
        end
        if (!ring) begin
            vy = s.left ? 16384 : -16384;
        end else begin
            for (int i = 0; i < NS; i++) begin
                sx[i] = 0; sy[i] = 0; cnt[i] = 0;
            end
            for (int i = 0; i < NS; i++) begin
                lit = s.ring[i];
                nxt = s.ring[(i + 1) % NS];
                if (lit && idx < NS) begin
                    sx[idx] += unit_x[i]; sy[idx] += unit_y[i]; cnt[idx]++;
                end
                if (lit && !nxt) idx++;
            end
            if (s.ring == 32'hFFFF_FFFF) begin
                nclus = 1;
            end else begin
                if (s.ring[NS-1] && s.ring[0] && idx < NS) begin
                    sx[0] += sx[idx]; sy[0] += sy[idx]; cnt[0] += cnt[idx];
                end
                nclus = idx;
            end
            for (int i = 0; i < nclus; i++) begin
                if (cnt[i] > 0) begin
                    vx += round_div(sx[i], cnt[i]);
                    vy += round_div(sy[i], cnt[i]);
                end
            end
        end
        ang = heading(vx, vy);
        dv = nclus ? nclus : 1;
        len_q = (int_sqrt(vx * vx + vy * vy) + dv / 2) / dv;
        if (len_q > 16384) len_q = 16384;
        prev = tracking ? longint'(held_angle) : ang;
        diff = ang - prev;
        if (diff < 0) diff = -diff;
        if (diff > 18000) diff = 36000 - diff;
        if (diff > longint'(jump_limit)) ang = prev;
        held_angle = 16'(ang);
        tracking = 1'b1;
        e.found = 1'b1;
        e.ring = ring;
        e.side = side;
        e.clusters = 5'(nclus);
        e.angle = 16'(ang);
        e.distance = 15'(len_q);
        return e;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("error: %s got %0d expected %0d", what, got, want);
        errors++;
    endtask

    // driver
    int send_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else if (req_ch.valid && req_ch.ready) begin
            expected_estimates.push_back(estimate_line(
                {req_ch.ring_bits, req_ch.right_side, req_ch.left_side}));
            send_gap = $urandom_range(0, 5);
            if (send_gap == 0 && !pause_send && pending_samples.size() > 0) begin
                {req_ch.ring_bits, req_ch.right_side, req_ch.left_side}
                    <= pending_samples.pop_front();
            end else begin
                req_ch.valid <= 1'b0;
            end
        end else if (!req_ch.valid) begin
            if (send_gap > 0) begin
                send_gap--;
            end else if (!pause_send && pending_samples.size() > 0) begin
                {req_ch.ring_bits, req_ch.right_side, req_ch.left_side}
                    <= pending_samples.pop_front();
                req_ch.valid <= 1'b1;
            end
        end
    end

    // monitor
    int recv_gap = 0;
    t_estimate want;
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout");
            $display("ring_line_direction_estimator_core: mismatch");
            $finish;
        end
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (expected_estimates.size() == 0) begin
                    report_mismatch("unexpected result", 1, 0);
                end else begin
                    want = expected_estimates.pop_front();
                    if (res_ch.line_found !== want.found)
                        report_mismatch("line_found", res_ch.line_found, want.found);
                    if (res_ch.ring_hit !== want.ring)
                        report_mismatch("ring_hit", res_ch.ring_hit, want.ring);
                    if (res_ch.side_hit !== want.side)
                        report_mismatch("side_hit", res_ch.side_hit, want.side);
                    if (res_ch.cluster_count !== want.clusters)
                        report_mismatch("cluster_count", res_ch.cluster_count, want.clusters);
                    if (res_ch.line_angle !== want.angle)
                        report_mismatch("line_angle", res_ch.line_angle, want.angle);
                    if (res_ch.line_distance !== want.distance)
                        report_mismatch("line_distance", res_ch.line_distance,
                                        want.distance);
                end
                recv_gap = $urandom_range(0, 5);
            end
            if (hold_off > 0) begin
                hold_off--;
                res_ch.ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    task automatic queue_sample(logic [31:0] r, logic rs, logic ls);
        pending_samples.push_back({r, rs, ls});
    endtask

    task automatic drain();
        while (pending_samples.size() > 0 || req_ch.valid || expected_estimates.size() > 0)
            @(negedge i_clk);
        repeat (600) @(posedge i_clk);
    endtask

    task automatic set_jump(logic [14:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        jump_limit = v;
    endtask

    function automatic logic [31:0] random_ring();
        logic [31:0] r;
        int start, len;
        case ($urandom_range(0, 5))
            0: r = $urandom;
            1: r = $urandom & $urandom;
            2: r = $urandom | $urandom;
            3: begin
                start = $urandom_range(0, 31);
                len = $urandom_range(1, 31);
                r = '0;
                for (int i = 0; i < len; i++) r[(start + i) % 32] = 1'b1;
            end
            4: r = 32'(1) << $urandom_range(0, 31);
            default: r = ($urandom_range(0, 3) == 0) ? 32'h0 : ($urandom & $urandom & $urandom);
        endcase
        return r;
    endfunction

    task automatic queue_random(int n);
        logic [31:0] r;
        for (int i = 0; i < n; i++) begin
            r = random_ring();
            queue_sample(r, $urandom_range(0, 1), $urandom_range(0, 1));
        end
    endtask

    initial begin
        logic [14:0] limits [5];
        limits = '{15'd0, 15'd18000, 15'h7FFF, 15'd500, 15'd9000};
        jump_limit = JUMP_RESET;
        held_angle = '0;
        tracking = 1'b0;
        build_units();
        req_ch.valid = 1'b0;
        req_ch.ring_bits = '0;
        req_ch.right_side = 1'b0;
        req_ch.left_side = 1'b0;
        res_ch.ready = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed
        queue_sample(32'h0, 0, 0);
        queue_sample(32'h0, 1, 0);
        queue_sample(32'h0, 0, 1);
        queue_sample(32'h0, 1, 1);
        queue_sample(32'h0, 0, 0);
        queue_sample(32'h0000_0001, 0, 0);
        queue_sample(32'h0001_0000, 0, 0);
        queue_sample(32'h0, 0, 0);
        queue_sample(32'h0001_0000, 1, 1);
        queue_sample(32'hFFFF_FFFF, 0, 0);
        queue_sample(32'hFFFF_FFFF, 1, 1);
        queue_sample(32'h8000_0001, 0, 0);
        queue_sample(32'hC000_0003, 1, 0);
        queue_sample(32'h5555_5555, 0, 0);
        queue_sample(32'hAAAA_AAAA, 0, 1);
        queue_sample(32'h0001_0001, 0, 0);
        queue_sample(32'h7FFF_FFFF, 0, 0);
        queue_sample(32'hFFFF_FFFE, 0, 0);
        queue_sample(32'h8000_0000, 0, 0);
        queue_sample(32'h0000_0100, 0, 0);
        queue_sample(32'h0100_0000, 0, 0);
        queue_sample(32'h8F0F_00F1, 1, 1);
        drain();

        // receiver stalls long while samples keep coming
        hold_off = 3000;
        queue_random(20);
        drain();

        for (int p = 0; p < 5; p++) begin
            set_jump(limits[p]);
            queue_random(180);
            // sender pauses until everything has come back
            pause_send = 1'b1;
            while (req_ch.valid || expected_estimates.size() > 0) @(negedge i_clk);
            pause_send = 1'b0;
            queue_random(180);
            drain();
        end
        set_jump(15'd3000);
        queue_random(50);
        drain();

        if (errors == 0) begin
            $display("ring_line_direction_estimator_core: match");
        end else begin
            $display("ring_line_direction_estimator_core: mismatch");
        end
        $finish;
    end
endmodule
